[rtl/fss_pkg.sv]
// shared types, codes and constants of the flash save sequencer
package fss_pkg;

    localparam int unsigned ADDR_W           = 24;
    localparam int unsigned NOW_W            = 32;
    localparam int unsigned TIMEOUT_W        = 16;
    localparam int unsigned FIELD_W          = 9;
    localparam int unsigned CFG_IDX_W        = 2;
    localparam int unsigned CFG_DATA_W       = 24;
    localparam int unsigned DEF_RECORD_BYTES = 512;
    localparam int unsigned DEF_PAGE_BYTES   = 256;

    localparam logic [TIMEOUT_W-1:0] ERASE_TIMEOUT_RST   = 16'd500;
    localparam logic [TIMEOUT_W-1:0] PROGRAM_TIMEOUT_RST = 16'd20;

    typedef enum logic {
        FUNC_REQUEST = 1'b0,
        FUNC_TICK    = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_ERASE   = 2'd1,
        ACT_PROGRAM = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        STORE_NONE   = 2'd0,
        STORE_ACTIVE = 2'd1,
        STORE_QUEUED = 2'd2
    } t_store;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ADDR       = 2'd0,
        CFG_FLASH_PRESENT   = 2'd1,
        CFG_ERASE_TIMEOUT   = 2'd2,
        CFG_PROGRAM_TIMEOUT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_func             func;
        logic              sr_read_ok;
        logic              flash_busy;
        logic              issue_ok;
        logic [NOW_W-1:0]  now_ms;
    } t_item;

    typedef struct packed {
        logic [ADDR_W-1:0]    base_addr;
        logic                 flash_present;
        logic [TIMEOUT_W-1:0] erase_timeout_ms;
        logic [TIMEOUT_W-1:0] program_timeout_ms;
    } t_cfg;

    typedef struct packed {
        t_action             action;
        logic [ADDR_W-1:0]   flash_addr;
        logic [FIELD_W-1:0]  record_offset;
        logic [FIELD_W-1:0]  chunk_len;
        logic                promote_queued;
        logic                save_done;
        logic                aborted;
        logic                request_status;
        t_store              stored_to;
        logic                saving;
    } t_result;

endpackage

[rtl/fss_cfg_regs.sv]
// configuration registers and page offset of the sector base address
module fss_cfg_regs import fss_pkg::*; #(
    parameter int unsigned PAGE_BYTES = DEF_PAGE_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    output t_cfg                          o_cfg,
    output logic [$clog2(PAGE_BYTES)-1:0] o_base_off
);

    localparam int unsigned OFF_W       = $clog2(PAGE_BYTES);
    localparam int unsigned RECIP_SHIFT = ADDR_W + OFF_W + 1;
    localparam int unsigned RECIP_W     = ADDR_W + 3;
    localparam int unsigned PROD_W      = ADDR_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << RECIP_SHIFT) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES));

    t_cfg               r_cfg;
    logic [PROD_W-1:0]  r_base_prod;
    logic [OFF_W-1:0]   r_base_off;
    logic [ADDR_W-1:0]  quot;
    logic [ADDR_W-1:0]  quot_page;
    logic [ADDR_W-1:0]  rem;
    logic [OFF_W-1:0]   n_base_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_addr          <= '0;
            r_cfg.flash_present      <= 1'b0;
            r_cfg.erase_timeout_ms   <= ERASE_TIMEOUT_RST;
            r_cfg.program_timeout_ms <= PROGRAM_TIMEOUT_RST;
            r_base_prod              <= '0;
            r_base_off               <= '0;
        end else begin
            r_base_off <= n_base_off;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_BASE_ADDR: begin
                        r_cfg.base_addr <= i_cfg_data[ADDR_W-1:0];
                        r_base_prod     <= PROD_W'(i_cfg_data[ADDR_W-1:0])
                                           * PROD_W'(RECIP);
                    end
                    CFG_FLASH_PRESENT: begin
                        r_cfg.flash_present <= i_cfg_data[0];
                    end
                    CFG_ERASE_TIMEOUT: begin
                        r_cfg.erase_timeout_ms <= i_cfg_data[TIMEOUT_W-1:0];
                    end
                    CFG_PROGRAM_TIMEOUT: begin
                        r_cfg.program_timeout_ms <= i_cfg_data[TIMEOUT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // base modulo page size by reciprocal multiply, one correction step
    always_comb begin
        quot      = ADDR_W'(r_base_prod >> RECIP_SHIFT);
        quot_page = ADDR_W'(quot * ADDR_W'(PAGE_BYTES));
        rem       = r_cfg.base_addr - quot_page;
        if (rem >= ADDR_W'(PAGE_BYTES)) begin
            rem = rem - ADDR_W'(PAGE_BYTES);
        end
        n_base_off = OFF_W'(rem);
    end

    assign o_cfg      = r_cfg;
    assign o_base_off = r_base_off;

endmodule

[rtl/fss_core.sv]
// sequencer state and the per-transaction step logic
module fss_core import fss_pkg::*; #(
    parameter int unsigned RECORD_BYTES = DEF_RECORD_BYTES,
    parameter int unsigned PAGE_BYTES   = DEF_PAGE_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  t_item                         i_item,
    input  t_cfg                          i_cfg,
    input  logic [$clog2(PAGE_BYTES)-1:0] i_base_off,
    output t_result                       o_result
);

    localparam int unsigned OFF_W   = $clog2(PAGE_BYTES);
    localparam int unsigned BYTES_W = $clog2(RECORD_BYTES + 1);
    localparam int unsigned CHUNK_W = $clog2(PAGE_BYTES + 1);
    localparam int unsigned LEN_W   = (BYTES_W > CHUNK_W) ? BYTES_W : CHUNK_W;
    // page offset after a chunk that runs past the top of the address space
    localparam logic [OFF_W-1:0] WRAP_OFF = OFF_W'(
        (PAGE_BYTES - ((1 << ADDR_W) % PAGE_BYTES)) % PAGE_BYTES);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ERASE   = 2'd1,
        PH_PROGRAM = 2'd2
    } t_phase;

    t_phase               r_phase,       n_phase;
    logic [BYTES_W-1:0]   r_bytes_done,  n_bytes_done;
    logic                 r_pending,     n_pending;
    logic [NOW_W-1:0]     r_step_start,  n_step_start;
    logic [OFF_W-1:0]     r_page_off,    n_page_off;

    t_result              res;
    logic                 start_erase;
    logic                 abort;
    logic [TIMEOUT_W-1:0] limit;
    logic [NOW_W-1:0]     elapsed;
    logic [ADDR_W-1:0]    prog_addr;
    logic [OFF_W-1:0]     cur_off;
    logic [CHUNK_W-1:0]   chunk_page;
    logic [BYTES_W-1:0]   left;
    logic [LEN_W-1:0]     chunk;
    logic [ADDR_W:0]      addr_sum;

    always_comb begin
        n_phase      = r_phase;
        n_bytes_done = r_bytes_done;
        n_pending    = r_pending;
        n_step_start = r_step_start;
        n_page_off   = r_page_off;
        res          = '0;
        start_erase  = 1'b0;
        abort        = 1'b0;

        limit   = (r_phase == PH_ERASE) ? i_cfg.erase_timeout_ms
                                        : i_cfg.program_timeout_ms;
        elapsed = i_item.now_ms - r_step_start;

        prog_addr  = i_cfg.base_addr + ADDR_W'(r_bytes_done);
        cur_off    = (r_bytes_done == '0) ? i_base_off : r_page_off;
        chunk_page = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(cur_off);
        left       = BYTES_W'(RECORD_BYTES) - r_bytes_done;
        chunk      = (LEN_W'(chunk_page) > LEN_W'(left)) ? LEN_W'(left)
                                                         : LEN_W'(chunk_page);
        addr_sum   = {1'b0, prog_addr} + (ADDR_W + 1)'(chunk);

        case (i_item.func)
            FUNC_REQUEST: begin
                if (!i_cfg.flash_present) begin
                    res.request_status = 1'b1;
                end else if (r_phase != PH_IDLE) begin
                    n_pending     = 1'b1;
                    res.stored_to = STORE_QUEUED;
                end else begin
                    res.stored_to      = STORE_ACTIVE;
                    start_erase        = 1'b1;
                    res.request_status = !i_item.issue_ok;
                end
            end
            FUNC_TICK: begin
                if (r_phase != PH_IDLE) begin
                    if (!i_item.sr_read_ok) begin
                        abort = 1'b1;
                    end else if (i_item.flash_busy) begin
                        if (elapsed > NOW_W'(limit)) begin
                            abort = 1'b1;
                        end
                    end else if (r_bytes_done < BYTES_W'(RECORD_BYTES)) begin
                        res.action        = ACT_PROGRAM;
                        res.flash_addr    = prog_addr;
                        res.record_offset = FIELD_W'(r_bytes_done);
                        res.chunk_len     = FIELD_W'(chunk);
                        n_step_start      = i_item.now_ms;
                        if (!i_item.issue_ok) begin
                            abort = 1'b1;
                        end else begin
                            n_bytes_done = r_bytes_done + BYTES_W'(chunk);
                            n_phase      = PH_PROGRAM;
                            n_page_off   = addr_sum[ADDR_W] ? WRAP_OFF : '0;
                        end
                    end else begin
                        res.save_done = 1'b1;
                        n_phase       = PH_IDLE;
                        if (r_pending) begin
                            n_pending          = 1'b0;
                            res.promote_queued = 1'b1;
                            start_erase        = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        if (start_erase) begin
            n_bytes_done   = '0;
            res.action     = ACT_ERASE;
            res.flash_addr = i_cfg.base_addr;
            n_step_start   = i_item.now_ms;
            if (i_item.issue_ok) begin
                n_phase = PH_ERASE;
            end else begin
                abort = 1'b1;
            end
        end

        if (abort) begin
            n_phase   = PH_IDLE;
            n_pending = 1'b0;
        end

        res.aborted = abort;
        res.saving  = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bytes_done <= '0;
            r_pending    <= 1'b0;
            r_step_start <= '0;
            r_page_off   <= '0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_bytes_done <= n_bytes_done;
            r_pending    <= n_pending;
            r_step_start <= n_step_start;
            r_page_off   <= n_page_off;
        end
    end

    assign o_result = res;

    a_abort_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.aborted |=> r_phase == PH_IDLE && !r_pending)
        else $error("abort did not return to idle with the queue dropped");

    a_program_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.action == ACT_PROGRAM && !res.aborted |=> r_phase == PH_PROGRAM)
        else $error("accepted page program did not enter the program phase");

    a_bytes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_done <= BYTES_W'(RECORD_BYTES))
        else $error("programmed byte count beyond the record size");

    a_done_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && res.save_done |-> r_bytes_done == BYTES_W'(RECORD_BYTES))
        else $error("save reported done before the whole record was written");

    a_saving_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |=> (r_phase != PH_IDLE) == $past(res.saving))
        else $error("saving flag disagrees with the phase that follows");

endmodule

[rtl/flash_save_sequencer_unit.sv]
// Flash save sequencer: takes save requests and poll ticks and returns one
// command descriptor per transaction (sector erase or page-bounded program
// chunk, plus done, abort and request status). One transaction is accepted
// every clock cycle when the result side keeps up; each transaction waits in
// the input register while the step logic works on it, and its result is
// then loaded into the output register. The step logic (base address add,
// page offset select, chunk limit and the 32-bit timeout compare) sets the
// cycle time. After a base_addr write, its page offset is registered from a
// registered reciprocal product of base_addr. PAGE_BYTES need not be a
// power of two.
module flash_save_sequencer_unit import fss_pkg::*; #(
    parameter int unsigned RECORD_BYTES = DEF_RECORD_BYTES,
    parameter int unsigned PAGE_BYTES   = DEF_PAGE_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_func,
    input  logic                  i_sr_read_ok,
    input  logic                  i_flash_busy,
    input  logic                  i_issue_ok,
    input  logic [NOW_W-1:0]      i_now_ms,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_action,
    output logic [ADDR_W-1:0]     o_flash_addr,
    output logic [FIELD_W-1:0]    o_record_offset,
    output logic [FIELD_W-1:0]    o_chunk_len,
    output logic                  o_promote_queued,
    output logic                  o_save_done,
    output logic                  o_aborted,
    output logic                  o_request_status,
    output logic [1:0]            o_stored_to,
    output logic                  o_saving
);

    localparam int unsigned OFF_W = $clog2(PAGE_BYTES);

    logic             r_in_valid;
    t_item            r_item;
    logic             r_out_valid;
    t_result          r_result;
    logic             advance;
    t_cfg             cfg;
    logic [OFF_W-1:0] base_off;
    t_result          step_res;

    fss_cfg_regs #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_base_off (base_off)
    );

    fss_core #(
        .RECORD_BYTES (RECORD_BYTES),
        .PAGE_BYTES   (PAGE_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (advance),
        .i_item     (r_item),
        .i_cfg      (cfg),
        .i_base_off (base_off),
        .o_result   (step_res)
    );

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // transaction payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.func       <= t_func'(i_func);
            r_item.sr_read_ok <= i_sr_read_ok;
            r_item.flash_busy <= i_flash_busy;
            r_item.issue_ok   <= i_issue_ok;
            r_item.now_ms     <= i_now_ms;
        end
        if (advance) begin
            r_result <= step_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_action         = r_result.action;
    assign o_flash_addr     = r_result.flash_addr;
    assign o_record_offset  = r_result.record_offset;
    assign o_chunk_len      = r_result.chunk_len;
    assign o_promote_queued = r_result.promote_queued;
    assign o_save_done      = r_result.save_done;
    assign o_aborted        = r_result.aborted;
    assign o_request_status = r_result.request_status;
    assign o_stored_to      = r_result.stored_to;
    assign o_saving         = r_result.saving;

endmodule

[tb/fss_descriptor_checker.sv]
// checker for the flash save sequencer: predicts every descriptor and compares it with the block
`timescale 1ns / 100ps

module fss_descriptor_checker import fss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_func,
    input  logic                  i_sr_read_ok,
    input  logic                  i_flash_busy,
    input  logic                  i_issue_ok,
    input  logic [NOW_W-1:0]      i_now_ms,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [1:0]            i_action,
    input  logic [ADDR_W-1:0]     i_flash_addr,
    input  logic [FIELD_W-1:0]    i_record_offset,
    input  logic [FIELD_W-1:0]    i_chunk_len,
    input  logic                  i_promote_queued,
    input  logic                  i_save_done,
    input  logic                  i_aborted,
    input  logic                  i_request_status,
    input  logic [1:0]            i_stored_to,
    input  logic                  i_saving,
    output logic [31:0]           o_fail_count,
    output logic [31:0]           o_pending,
    output logic                  o_save_active
);

    localparam int unsigned RECORD_LEN = DEF_RECORD_BYTES;
    localparam int unsigned PAGE_LEN   = DEF_PAGE_BYTES;

    typedef enum logic [1:0] {
        SAVE_IDLE    = 2'd0,
        SAVE_ERASE   = 2'd1,
        SAVE_PROGRAM = 2'd2
    } t_save_phase;

    logic [ADDR_W-1:0]    cfg_base;
    logic                 cfg_present;
    logic [TIMEOUT_W-1:0] cfg_erase_ms;
    logic [TIMEOUT_W-1:0] cfg_program_ms;

    t_save_phase      save_phase;
    int unsigned      bytes_written;
    logic             request_waiting;
    logic [NOW_W-1:0] step_ms;

    t_result     expected_descriptors[$];
    int unsigned fails;
    int unsigned seen_count;

    initial begin
        o_fail_count  = '0;
        o_pending     = '0;
        o_save_active = 1'b0;
        fails         = 0;
        seen_count    = 0;
    end

    task automatic drop_save(inout t_result r);
        save_phase      = SAVE_IDLE;
        request_waiting = 1'b0;
        r.aborted       = 1'b1;
    endtask

    task automatic open_erase(input t_item it, inout t_result r);
        bytes_written = 0;
        r.action      = ACT_ERASE;
        r.flash_addr  = cfg_base;
        step_ms       = it.now_ms;
        if (!it.issue_ok) begin
            drop_save(r);
        end else begin
            save_phase = SAVE_ERASE;
        end
    endtask

    task automatic advance_sequencer(input t_item it, output t_result r);
        logic [ADDR_W-1:0]    addr;
        logic [NOW_W-1:0]     elapsed;
        logic [TIMEOUT_W-1:0] limit;
        int unsigned          room;
        int unsigned          left;
        r = '0;
        if (it.func == FUNC_REQUEST) begin
            if (!cfg_present) begin
                r.request_status = 1'b1;
            end else if (save_phase != SAVE_IDLE) begin
                request_waiting = 1'b1;
                r.stored_to     = STORE_QUEUED;
            end else begin
                r.stored_to = STORE_ACTIVE;
                open_erase(it, r);
                if (r.aborted) r.request_status = 1'b1;
            end
        end else if (save_phase != SAVE_IDLE) begin
            if (!it.sr_read_ok) begin
                drop_save(r);
            end else if (it.flash_busy) begin
                limit   = (save_phase == SAVE_ERASE) ? cfg_erase_ms : cfg_program_ms;
                elapsed = it.now_ms - step_ms;
                if (elapsed > {16'd0, limit}) drop_save(r);
            end else if (bytes_written < RECORD_LEN) begin
                addr = cfg_base + bytes_written[ADDR_W-1:0];
                room = PAGE_LEN - (int'(addr) % PAGE_LEN);
                left = RECORD_LEN - bytes_written;
                if (room > left) room = left;
                r.action        = ACT_PROGRAM;
                r.flash_addr    = addr;
                r.record_offset = bytes_written[FIELD_W-1:0];
                r.chunk_len     = room[FIELD_W-1:0];
                step_ms         = it.now_ms;
                if (!it.issue_ok) begin
                    drop_save(r);
                end else begin
                    bytes_written = bytes_written + room;
                    save_phase    = SAVE_PROGRAM;
                end
            end else begin
                r.save_done = 1'b1;
                save_phase  = SAVE_IDLE;
                if (request_waiting) begin
                    request_waiting  = 1'b0;
                    r.promote_queued = 1'b1;
                    open_erase(it, r);
                end
            end
        end
        r.saving = (save_phase != SAVE_IDLE);
    endtask

    function automatic string describe(input t_result r);
        return $sformatf("act=%0d addr=%06h off=%0d len=%0d prom=%0b done=%0b abort=%0b st=%0b to=%0d busy=%0b",
            r.action, r.flash_addr, r.record_offset, r.chunk_len, r.promote_queued,
            r.save_done, r.aborted, r.request_status, r.stored_to, r.saving);
    endfunction

    always @(posedge i_clk) begin
        t_item   it;
        t_result want;
        t_result seen;
        string   diffs;
        if (!i_rst_n) begin
            cfg_base        = '0;
            cfg_present     = 1'b0;
            cfg_erase_ms    = ERASE_TIMEOUT_RST;
            cfg_program_ms  = PROGRAM_TIMEOUT_RST;
            save_phase      = SAVE_IDLE;
            bytes_written   = 0;
            request_waiting = 1'b0;
            step_ms         = '0;
            expected_descriptors.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_BASE_ADDR:       cfg_base       = i_cfg_data[ADDR_W-1:0];
                    CFG_FLASH_PRESENT:   cfg_present    = i_cfg_data[0];
                    CFG_ERASE_TIMEOUT:   cfg_erase_ms   = i_cfg_data[TIMEOUT_W-1:0];
                    CFG_PROGRAM_TIMEOUT: cfg_program_ms = i_cfg_data[TIMEOUT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                it.func       = t_func'(i_func);
                it.sr_read_ok = i_sr_read_ok;
                it.flash_busy = i_flash_busy;
                it.issue_ok   = i_issue_ok;
                it.now_ms     = i_now_ms;
                advance_sequencer(it, want);
                expected_descriptors.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                seen.action         = t_action'(i_action);
                seen.flash_addr     = i_flash_addr;
                seen.record_offset  = i_record_offset;
                seen.chunk_len      = i_chunk_len;
                seen.promote_queued = i_promote_queued;
                seen.save_done      = i_save_done;
                seen.aborted        = i_aborted;
                seen.request_status = i_request_status;
                seen.stored_to      = t_store'(i_stored_to);
                seen.saving         = i_saving;
                if (expected_descriptors.size() == 0) begin
                    if (fails < 10)
                        $display("descriptor %0d arrived with nothing expected: %s",
                            seen_count, describe(seen));
                    fails++;
                end else begin
                    want  = expected_descriptors.pop_front();
                    diffs = "";
                    if (seen.action !== want.action)                 diffs = {diffs, " action"};
                    if (seen.flash_addr !== want.flash_addr)         diffs = {diffs, " addr"};
                    if (seen.record_offset !== want.record_offset)   diffs = {diffs, " offset"};
                    if (seen.chunk_len !== want.chunk_len)           diffs = {diffs, " len"};
                    if (seen.promote_queued !== want.promote_queued) diffs = {diffs, " promote"};
                    if (seen.save_done !== want.save_done)           diffs = {diffs, " done"};
                    if (seen.aborted !== want.aborted)               diffs = {diffs, " aborted"};
                    if (seen.request_status !== want.request_status) diffs = {diffs, " status"};
                    if (seen.stored_to !== want.stored_to)           diffs = {diffs, " stored_to"};
                    if (seen.saving !== want.saving)                 diffs = {diffs, " saving"};
                    if (diffs != "") begin
                        if (fails < 10)
                            $display("descriptor %0d mismatch in%s: expected %s, got %s",
                                seen_count, diffs, describe(want), describe(seen));
                        fails++;
                    end
                end
                seen_count++;
            end
        end
        o_fail_count  <= fails;
        o_pending     <= expected_descriptors.size();
        o_save_active <= (save_phase != SAVE_IDLE);
    end

endmodule

[tb/tb_flash_save_sequencer_unit.sv]
// top of the flash save sequencer testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_flash_save_sequencer_unit;
    import fss_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 200;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_func;
    logic                  i_sr_read_ok;
    logic                  i_flash_busy;
    logic                  i_issue_ok;
    logic [NOW_W-1:0]      i_now_ms;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [1:0]            o_action;
    logic [ADDR_W-1:0]     o_flash_addr;
    logic [FIELD_W-1:0]    o_record_offset;
    logic [FIELD_W-1:0]    o_chunk_len;
    logic                  o_promote_queued;
    logic                  o_save_done;
    logic                  o_aborted;
    logic                  o_request_status;
    logic [1:0]            o_stored_to;
    logic                  o_saving;

    logic [31:0]      fail_count;
    logic [31:0]      pending_count;
    logic             save_active;
    logic             hold_off_req = 1'b0;
    logic [NOW_W-1:0] clock_ms;
    int unsigned      burst_left;
    int unsigned      quiet_cycles = 0;

    flash_save_sequencer_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_sr_read_ok     (i_sr_read_ok),
        .i_flash_busy     (i_flash_busy),
        .i_issue_ok       (i_issue_ok),
        .i_now_ms         (i_now_ms),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_action         (o_action),
        .o_flash_addr     (o_flash_addr),
        .o_record_offset  (o_record_offset),
        .o_chunk_len      (o_chunk_len),
        .o_promote_queued (o_promote_queued),
        .o_save_done      (o_save_done),
        .o_aborted        (o_aborted),
        .o_request_status (o_request_status),
        .o_stored_to      (o_stored_to),
        .o_saving         (o_saving)
    );

    fss_descriptor_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_sr_read_ok     (i_sr_read_ok),
        .i_flash_busy     (i_flash_busy),
        .i_issue_ok       (i_issue_ok),
        .i_now_ms         (i_now_ms),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_action         (o_action),
        .i_flash_addr     (o_flash_addr),
        .i_record_offset  (o_record_offset),
        .i_chunk_len      (o_chunk_len),
        .i_promote_queued (o_promote_queued),
        .i_save_done      (o_save_done),
        .i_aborted        (o_aborted),
        .i_request_status (o_request_status),
        .i_stored_to      (o_stored_to),
        .i_saving         (o_saving),
        .o_fail_count     (fail_count),
        .o_pending        (pending_count),
        .o_save_active    (save_active)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("flash_save_sequencer_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random runs and stalls, one long hold-off on request
    initial begin
        int unsigned run;
        int unsigned stall;
        i_out_ready <= 1'b0;
        forever begin
            run   = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            i_out_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
        end
    end

    function automatic t_item pack_item(input t_func func, input logic sr_ok,
                                        input logic busy, input logic iss_ok,
                                        input logic [NOW_W-1:0] now);
        t_item it;
        it.func       = func;
        it.sr_read_ok = sr_ok;
        it.flash_busy = busy;
        it.issue_ok   = iss_ok;
        it.now_ms     = now;
        return it;
    endfunction

    // called just after a rising edge, returns just after the accepting edge
    task automatic offer(input t_item it);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_func       <= it.func;
        i_sr_read_ok <= it.sr_read_ok;
        i_flash_busy <= it.flash_busy;
        i_issue_ok   <= it.issue_ok;
        i_now_ms     <= it.now_ms;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // waits for every descriptor, then writes all four registers
    task automatic write_settings(input logic [ADDR_W-1:0] base, input logic present,
                                  input logic [TIMEOUT_W-1:0] erase_ms,
                                  input logic [TIMEOUT_W-1:0] program_ms);
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BASE_ADDR;
        i_cfg_data <= base;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FLASH_PRESENT;
        i_cfg_data <= {23'd0, present};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ERASE_TIMEOUT;
        i_cfg_data <= {8'd0, erase_ms};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_PROGRAM_TIMEOUT;
        i_cfg_data <= {8'd0, program_ms};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        repeat (2) @(posedge i_clk);
    endtask

    task automatic run_phase(input int unsigned n_items, input logic with_hold);
        t_item       it;
        int unsigned roll;
        if (with_hold) hold_off_req = 1'b1;
        repeat (n_items) begin
            roll          = $urandom_range(0, 99);
            it.func       = (roll < (save_active ? 8 : 75)) ? FUNC_REQUEST : FUNC_TICK;
            it.sr_read_ok = ($urandom_range(0, 99) < 96);
            it.flash_busy = 1'($urandom_range(0, 1));
            it.issue_ok   = ($urandom_range(0, 99) < 94);
            roll          = $urandom_range(0, 99);
            if (roll < 80)      clock_ms = clock_ms + $urandom_range(0, 4);
            else if (roll < 95) clock_ms = clock_ms + $urandom_range(0, 70000);
            else                clock_ms = $urandom;
            it.now_ms = clock_ms;
            offer(it);
        end
        i_in_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_BASE_ADDR;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_func       <= FUNC_TICK;
        i_sr_read_ok <= 1'b0;
        i_flash_busy <= 1'b0;
        i_issue_ok   <= 1'b0;
        i_now_ms     <= '0;
        clock_ms     = '0;
        burst_left   = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: no flash, so requests fail and ticks do nothing
        offer(pack_item(FUNC_REQUEST, 1'b1, 1'b0, 1'b1, 32'd7));
        offer(pack_item(FUNC_TICK, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF));
        i_in_valid <= 1'b0;

        // unaligned base near the top so the record wraps the address space
        write_settings(24'hFFFF80, 1'b1, 16'hFFFF, 16'd1);
        offer(pack_item(FUNC_REQUEST, 1'b1, 1'b0, 1'b0, 32'd5));
        offer(pack_item(FUNC_REQUEST, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFF0));
        offer(pack_item(FUNC_REQUEST, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFF4));
        offer(pack_item(FUNC_TICK, 1'b1, 1'b1, 1'b1, 32'h0000_FFF0));
        offer(pack_item(FUNC_TICK, 1'b0, 1'b1, 1'b0, 32'h0001_0000));
        offer(pack_item(FUNC_REQUEST, 1'b1, 1'b0, 1'b1, 32'd100));
        offer(pack_item(FUNC_TICK, 1'b1, 1'b1, 1'b1, 32'd65635));
        offer(pack_item(FUNC_TICK, 1'b1, 1'b0, 1'b1, 32'd65636));
        offer(pack_item(FUNC_TICK, 1'b1, 1'b1, 1'b1, 32'd65637));
        offer(pack_item(FUNC_REQUEST, 1'b1, 1'b0, 1'b1, 32'd65637));
        offer(pack_item(FUNC_TICK, 1'b1, 1'b0, 1'b1, 32'd65638));
        offer(pack_item(FUNC_TICK, 1'b1, 1'b0, 1'b1, 32'd65639));
        offer(pack_item(FUNC_TICK, 1'b1, 1'b0, 1'b1, 32'd65640));
        offer(pack_item(FUNC_TICK, 1'b0, 1'b0, 1'b1, 32'd65641));
        // program busy past its one millisecond limit
        offer(pack_item(FUNC_REQUEST, 1'b1, 1'b0, 1'b1, 32'd200));
        offer(pack_item(FUNC_TICK, 1'b1, 1'b0, 1'b1, 32'd200));
        offer(pack_item(FUNC_TICK, 1'b1, 1'b1, 1'b1, 32'd202));
        // program command refused by the bus
        offer(pack_item(FUNC_REQUEST, 1'b1, 1'b0, 1'b1, 32'd300));
        offer(pack_item(FUNC_TICK, 1'b1, 1'b0, 1'b0, 32'd301));
        // full save, queued record promoted but its erase refused
        offer(pack_item(FUNC_REQUEST, 1'b1, 1'b0, 1'b1, 32'd400));
        offer(pack_item(FUNC_TICK, 1'b1, 1'b0, 1'b1, 32'd401));
        offer(pack_item(FUNC_TICK, 1'b1, 1'b0, 1'b1, 32'd402));
        offer(pack_item(FUNC_TICK, 1'b1, 1'b0, 1'b1, 32'd403));
        offer(pack_item(FUNC_REQUEST, 1'b1, 1'b0, 1'b1, 32'd403));
        offer(pack_item(FUNC_TICK, 1'b1, 1'b0, 1'b0, 32'd404));
        i_in_valid <= 1'b0;

        clock_ms = 32'd1000;
        write_settings(24'h000000, 1'b1, 16'd500, 16'd20);
        run_phase(260, 1'b1);
        write_settings(24'hFFFFFF, 1'b1, 16'd1, 16'hFFFF);
        run_phase(260, 1'b0);
        write_settings(ADDR_W'($urandom_range(0, 24'hFFFFFF)), 1'b1, 16'hFFFF, 16'd1);
        run_phase(260, 1'b0);
        write_settings(ADDR_W'($urandom_range(0, 24'hFFFFFF)), 1'b0,
                       TIMEOUT_W'($urandom_range(1, 65535)), TIMEOUT_W'($urandom_range(1, 65535)));
        run_phase(60, 1'b0);
        write_settings(ADDR_W'($urandom_range(0, 24'hFFFFFF)), 1'b1,
                       TIMEOUT_W'($urandom_range(1, 40)), TIMEOUT_W'($urandom_range(1, 40)));
        run_phase(260, 1'b1);
        write_settings(ADDR_W'($urandom_range(0, 24'hFFFFFF)), 1'b1,
                       TIMEOUT_W'($urandom_range(1, 65535)), TIMEOUT_W'($urandom_range(1, 65535)));
        run_phase(260, 1'b0);
        write_settings(ADDR_W'($urandom_range(0, 24'hFFFFFF)), 1'b1, 16'd600, 16'd30);
        run_phase(200, 1'b0);

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("flash_save_sequencer_unit test passed");
        end else begin
            $display("flash_save_sequencer_unit test failed");
        end
        $finish;
    end

endmodule

[flash_save_sequencer_unit.f]
rtl/fss_pkg.sv
rtl/fss_cfg_regs.sv
rtl/fss_core.sv
rtl/flash_save_sequencer_unit.sv
tb/fss_descriptor_checker.sv
tb/tb_flash_save_sequencer_unit.sv
